// File: rtl/core/sorted_matrix_binary_search_defines.svh
// ----------------------------------------------------------------------------
// sorted_matrix_binary_search assertion macros
// Shared concurrent assertion forms for the binary search block checkers.
// ----------------------------------------------------------------------------
`ifndef SORTED_MATRIX_BINARY_SEARCH_DEFINES_SVH
`define SORTED_MATRIX_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication, reset masked
`define SMBS_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("smbs check failed");

// next-cycle implication, reset masked
`define SMBS_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("smbs check failed");

`endif

// File: rtl/core/smbs_pkg.sv
// ----------------------------------------------------------------------------
// smbs_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package smbs_pkg;

  localparam int MAX_ROWS_DEFAULT    = 32;
  localparam int MAX_COLUMNS_DEFAULT = 32;

  localparam int VALUE_W     = 32;
  localparam int REG_W       = 6;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] ROW_COUNT_IDX    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] COLUMN_COUNT_IDX = 1'b1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic store_write;
    logic latch_key;
    logic size_calc;
    logic first;
    logic step;
  } smbs_cmd_t;

  typedef struct packed {
    logic hit;
    logic more;
  } smbs_status_t;

endpackage

// File: rtl/core/smbs_datapath.sv
// ----------------------------------------------------------------------------
// smbs_datapath
// Element store, configuration registers and search bound arithmetic.
// ----------------------------------------------------------------------------
module smbs_datapath
  import smbs_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  logic signed [VALUE_W-1:0] value,
  input  smbs_cmd_t              cmd,
  output smbs_status_t           status
);

  localparam int Depth = MAX_ROWS * MAX_COLUMNS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PosW  = $clog2(Depth + 1);
  localparam int RowW  = $clog2(MAX_ROWS + 1);
  localparam int ColW  = $clog2(MAX_COLUMNS + 1);

  logic signed [VALUE_W-1:0] mem [Depth];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] key;

  logic [RowW-1:0]      rows;
  logic [ColW-1:0]      cols;
  logic [RowW+ColW-1:0] prod;
  logic [PosW-1:0]      count;
  logic [PosW-1:0]      load_position;
  logic [PosW-1:0]      low;
  logic [PosW-1:0]      high;
  logic [AddrW-1:0]     mid;

  logic [PosW-1:0]  low_next;
  logic [PosW-1:0]  high_next;
  logic [PosW:0]    mid_sum;
  logic [AddrW-1:0] mid_next;
  logic             mid_plus_w;

  // configuration, saturated to the store geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
      cols <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ROW_COUNT_IDX: begin
          if (int'(cfg_data) > MAX_ROWS) rows <= RowW'(MAX_ROWS);
          else rows <= RowW'(cfg_data);
        end
        COLUMN_COUNT_IDX: begin
          if (int'(cfg_data) > MAX_COLUMNS) cols <= ColW'(MAX_COLUMNS);
          else cols <= ColW'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // load pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
    end else if (cmd.store_write && load_position < PosW'(Depth)) begin
      load_position <= load_position + 1'b1;
    end
  end

  // element store
  always_ff @(posedge clk) begin
    if (cmd.store_write && load_position < PosW'(Depth)) begin
      mem[load_position[AddrW-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.first || cmd.step) && status.more) begin
      rd_data <= mem[mid_next];
    end
  end

  assign prod = rows * cols;

  always_ff @(posedge clk) begin
    if (cmd.latch_key) key <= value;
    if (cmd.size_calc) count <= PosW'(prod);
  end

  // next bounds
  always_comb begin
    mid_plus_w = 1'b0;
    low_next   = low;
    high_next  = high;
    if (cmd.first) begin
      low_next  = '0;
      high_next = count;
    end else if (rd_data < key) begin
      mid_plus_w = 1'b1;
      low_next   = PosW'(mid) + 1'b1;
    end else begin
      high_next  = PosW'(mid);
    end
    mid_sum  = {1'b0, low_next} + {1'b0, high_next} - 1'b1;
    mid_next = mid_sum[AddrW:1];
  end

  assign status.hit  = (rd_data == key);
  assign status.more = (low_next < high_next) && (cmd.first || !status.hit || mid_plus_w);

  always_ff @(posedge clk) begin
    if (cmd.first || cmd.step) begin
      low  <= low_next;
      high <= high_next;
      mid  <= mid_next;
    end
  end

endmodule

// File: rtl/core/smbs_ctrl.sv
// ----------------------------------------------------------------------------
// smbs_ctrl
// Sequencer for loads and queries, result register and handshakes.
// ----------------------------------------------------------------------------
module smbs_ctrl
  import smbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  logic         kind,
  output logic         result_valid,
  input  logic         result_stall,
  output logic         found,
  output smbs_cmd_t    cmd,
  input  smbs_status_t status
);

  typedef enum logic [4:0] {
    IDLE  = 5'b00001,
    SIZE  = 5'b00010,
    FIRST = 5'b00100,
    PROBE = 5'b01000,
    DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   found_next;
  logic   accept;

  assign item_stall   = (state != IDLE);
  assign result_valid = (state == DONE);
  assign accept       = item_valid && (state == IDLE);

  always_comb begin
    cmd             = '0;
    cmd.store_write = accept && (kind == KIND_LOAD);
    cmd.latch_key   = accept && (kind == KIND_QUERY);
    cmd.size_calc   = (state == SIZE);
    cmd.first       = (state == FIRST);
    cmd.step        = (state == PROBE) && !status.hit;
  end

  always_comb begin
    state_next = state;
    found_next = found;
    case (state)
      IDLE: begin
        if (accept && kind == KIND_QUERY) state_next = SIZE;
      end
      SIZE: state_next = FIRST;
      FIRST: begin
        if (status.more) begin
          state_next = PROBE;
        end else begin
          found_next = 1'b0;
          state_next = DONE;
        end
      end
      PROBE: begin
        if (status.hit) begin
          found_next = 1'b1;
          state_next = DONE;
        end else if (!status.more) begin
          found_next = 1'b0;
          state_next = DONE;
        end
      end
      DONE: begin
        if (!result_stall) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    found <= found_next;
  end

endmodule

// File: rtl/core/sorted_matrix_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_matrix_binary_search
// A load beat writes the next store entry and leaves the block idle. A query
// beat runs a binary search over the first rows*columns entries with one
// store read per cycle: the result is offered once the SIZE, FIRST and PROBE
// states are through, after p probes (at most clog2(rows*columns)+1, so 11
// for a full 32x32 store). The next beat is taken the cycle after the result
// leaves. The single read port of the element store sets the probe rate.
// ----------------------------------------------------------------------------
module sorted_matrix_binary_search
  import smbs_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]          cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      kind,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      found
);

  smbs_cmd_t    cmd;
  smbs_status_t status;

  assign cfg_ready = 1'b1;

  smbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .cmd          (cmd),
    .status       (status)
  );

  smbs_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (value),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: rtl/core/smbs_checker.sv
// ----------------------------------------------------------------------------
// smbs_checker
// Port-level checks for the binary search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_matrix_binary_search_defines.svh"

module smbs_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_stall,
  input logic kind,
  input logic result_valid,
  input logic result_stall,
  input logic found
);

  `SMBS_ASSERT_NEXT(held_result, clk, rst, result_valid && result_stall, result_valid && $stable(found))
  `SMBS_ASSERT_NEXT(query_busy, clk, rst, item_valid && !item_stall && kind, item_stall && !result_valid)
  `SMBS_ASSERT_NOW(one_in_flight, clk, rst, result_valid, item_stall)
  `SMBS_ASSERT_NEXT(load_silent, clk, rst, item_valid && !item_stall && !kind, !result_valid && !item_stall)

endmodule

bind sorted_matrix_binary_search smbs_checker u_checker (.*);
